### src/bmsd_pkg.sv
// ----------------------------------------------------------------------------
// bmsd_pkg
// Shared constants and types for the keypad scan and debounce core.
// ----------------------------------------------------------------------------
package bmsd_pkg;

   // Matrix geometry
   localparam int NUM_COLUMNS = 4;
   localparam int NUM_ROWS    = 4;
   localparam int COLOUR_BITS = 2;

   // Fixed field widths of the channels
   localparam int CNT_W      = 4;
   localparam int LEVEL_W    = 4;
   localparam int SCAN_COL_W = 2;
   localparam int LED_W      = 8;
   localparam int MASK_W     = 4;

   // Column index width
   localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   typedef enum logic [0:0] {
      REG_DEBOUNCE_LIMIT = 1'b0,
      REG_UNUSED         = 1'b1
   } reg_index_type;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 4'h3;

   // One memory entry: the state of all keys of one column
   typedef struct packed {
      logic [NUM_ROWS-1:0][CNT_W-1:0]       cnt;
      logic [NUM_ROWS-1:0][COLOUR_BITS-1:0] colour;
   } key_row_type;

   // Write request into the state memory
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      key_row_type      data;
   } mem_wr_type;

endpackage

### src/bmsd_channels.sv
// ----------------------------------------------------------------------------
// bmsd channel interfaces
// Valid/ready channels for scan slots in and scan results out.
// ----------------------------------------------------------------------------
interface bmsd_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmsd_pkg::LEVEL_W-1:0] row_levels;

   modport source (output valid, output row_levels, input ready);
   modport sink   (input valid, input row_levels, output ready);
endinterface

interface bmsd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bmsd_pkg::SCAN_COL_W-1:0] scan_column;
   logic [bmsd_pkg::LED_W-1:0]      led_drive;
   logic [bmsd_pkg::MASK_W-1:0]     key_down_mask;
   logic [bmsd_pkg::MASK_W-1:0]     key_up_mask;

   modport source (output valid, output scan_column, output led_drive,
                   output key_down_mask, output key_up_mask, input ready);
   modport sink   (input valid, input scan_column, input led_drive,
                   input key_down_mask, input key_up_mask, output ready);
endinterface

### src/bmsd_state_mem.sv
// ----------------------------------------------------------------------------
// bmsd_state_mem
// Per-column key state memory: one write port, one registered read port,
// write-to-read bypass and per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module bmsd_state_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [bmsd_pkg::COL_W-1:0] rd_addr,
   output bmsd_pkg::key_row_type      rd_data,
   input  bmsd_pkg::mem_wr_type       wr
);

   bmsd_pkg::key_row_type               state_mem_ff [bmsd_pkg::NUM_COLUMNS];
   logic [bmsd_pkg::NUM_COLUMNS-1:0]    vld_ff;
   logic [bmsd_pkg::NUM_COLUMNS-1:0]    vld_in;
   bmsd_pkg::key_row_type               rd_data_ff;

   // Mark written entries valid
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         state_mem_ff[wr.addr] <= wr.data;
      end
   end

   // Read port: bypass a same-cycle write, never-written entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else if (vld_ff[rd_addr]) begin
            rd_data_ff <= state_mem_ff[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bmsd_key_update.sv
// ----------------------------------------------------------------------------
// bmsd_key_update
// Integrating debounce and colour advance for all keys of one column.
// ----------------------------------------------------------------------------
module bmsd_key_update (
   input  bmsd_pkg::key_row_type            old_row,
   input  logic [bmsd_pkg::LEVEL_W-1:0]     row_levels,
   input  logic [bmsd_pkg::CNT_W-1:0]       limit,
   output bmsd_pkg::key_row_type            new_row,
   output logic [bmsd_pkg::NUM_ROWS-1:0]    down,
   output logic [bmsd_pkg::NUM_ROWS-1:0]    up
);

   // Rows beyond the level field see a low bit, i.e. pressed
   logic [bmsd_pkg::NUM_ROWS+bmsd_pkg::LEVEL_W-1:0] lv_ext;

   assign lv_ext = {{bmsd_pkg::NUM_ROWS{1'b0}}, row_levels};

   always_comb begin
      new_row = old_row;
      down    = '0;
      up      = '0;
      for (int r = 0; r < bmsd_pkg::NUM_ROWS; r++) begin
         if (!lv_ext[r]) begin
            // Count up toward the limit, flag key-down on reaching it
            if (old_row.cnt[r] < limit) begin
               new_row.cnt[r] = old_row.cnt[r] + 1'b1;
               if (new_row.cnt[r] == limit) begin
                  down[r]           = 1'b1;
                  new_row.colour[r] = old_row.colour[r] + 1'b1;
               end
            end
         end else if (old_row.cnt[r] != '0) begin
            // Count down toward zero, flag key-up on reaching it
            new_row.cnt[r] = old_row.cnt[r] - 1'b1;
            if (new_row.cnt[r] == '0) begin
               up[r] = 1'b1;
            end
         end
      end
   end

endmodule

### src/button_matrix_scan_debounce_core.sv
// ----------------------------------------------------------------------------
// button_matrix_scan_debounce_core
// Keypad matrix scanner: per-key integrating debounce and colour cycling,
// state held in a per-column memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | row_levels[3:0]
//  rsp     | out | valid / ready   | scan_column, led_drive, key down/up masks
//  csr     | in  | APB psel/penable| debounce_limit at byte address 0
//
//  One item per cycle sustained while results are taken; each item passes
//  the memory read register, then the update into the output register.
//  A same-column write is bypassed into the read. Synchronous reset clears
//  the column pointer, the memory valid bits and the limit (to 3); no
//  clearing pass. A stalled result holds the update stage; req stays ready
//  while the update stage can drain.
// ----------------------------------------------------------------------------
module button_matrix_scan_debounce_core (
   input  logic                            clock,
   input  logic                            reset,
   bmsd_req_if.sink                        req_if,
   bmsd_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bmsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bmsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [bmsd_pkg::CNT_W-1:0]   limit_ff;
   logic [bmsd_pkg::CNT_W-1:0]   limit_in;
   bmsd_pkg::reg_index_type      csr_index;

   logic [bmsd_pkg::COL_W-1:0]   col_ptr_ff;
   logic [bmsd_pkg::COL_W-1:0]   col_ptr_in;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [bmsd_pkg::COL_W-1:0]   s1_col_ff;
   logic [bmsd_pkg::LEVEL_W-1:0] s1_levels_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [bmsd_pkg::SCAN_COL_W-1:0] out_col_ff;
   logic [bmsd_pkg::LED_W-1:0]      out_led_ff;
   logic [bmsd_pkg::MASK_W-1:0]     out_down_ff;
   logic [bmsd_pkg::MASK_W-1:0]     out_up_ff;

   logic                         accept;
   logic                         s1_adv;
   logic                         s1_fire;
   bmsd_pkg::key_row_type        rd_row;
   bmsd_pkg::key_row_type        new_row;
   bmsd_pkg::mem_wr_type         mem_wr;
   logic [bmsd_pkg::NUM_ROWS-1:0] down;
   logic [bmsd_pkg::NUM_ROWS-1:0] up;

   logic [bmsd_pkg::NUM_ROWS*bmsd_pkg::COLOUR_BITS+bmsd_pkg::LED_W-1:0] led_ext;
   logic [bmsd_pkg::NUM_ROWS+bmsd_pkg::MASK_W-1:0] down_ext;
   logic [bmsd_pkg::NUM_ROWS+bmsd_pkg::MASK_W-1:0] up_ext;
   logic [bmsd_pkg::COL_W+bmsd_pkg::SCAN_COL_W-1:0] col_ext;

   // ---- configuration port ----
   assign csr_index  = bmsd_pkg::reg_index_type'(csr_paddr[bmsd_pkg::CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;

   // Decode register writes
   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            bmsd_pkg::REG_DEBOUNCE_LIMIT: limit_in = csr_pwdata[bmsd_pkg::CNT_W-1:0];
            bmsd_pkg::REG_UNUSED:         limit_in = limit_ff;
            default:                      limit_in = limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bmsd_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Decode register reads
   always_comb begin
      unique case (csr_index)
         bmsd_pkg::REG_DEBOUNCE_LIMIT:
            csr_prdata = {{(bmsd_pkg::CSR_DATA_W-bmsd_pkg::CNT_W){1'b0}}, limit_ff};
         bmsd_pkg::REG_UNUSED: csr_prdata = '0;
         default:              csr_prdata = '0;
      endcase
   end

   // ---- pipeline control ----
   assign s1_adv       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_if.valid && req_if.ready;
   assign s1_fire      = s1_valid_ff && s1_adv;

   always_comb begin
      // Advance the column pointer on each accepted item
      col_ptr_in = col_ptr_ff;
      if (accept) begin
         if (col_ptr_ff == bmsd_pkg::COL_W'(bmsd_pkg::NUM_COLUMNS - 1)) begin
            col_ptr_in = '0;
         end else begin
            col_ptr_in = col_ptr_ff + 1'b1;
         end
      end
      // Update stage occupancy
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      // Output register occupancy
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ptr_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ptr_ff   <= col_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the slot alongside the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= col_ptr_ff;
         s1_levels_ff <= req_if.row_levels;
      end
   end

   // ---- state memory and key update ----
   assign mem_wr.en   = s1_fire;
   assign mem_wr.addr = s1_col_ff;
   assign mem_wr.data = new_row;

   bmsd_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ptr_ff),
      .rd_data (rd_row),
      .wr      (mem_wr)
   );

   bmsd_key_update u_key_update (
      .old_row    (rd_row),
      .row_levels (s1_levels_ff),
      .limit      (limit_ff),
      .new_row    (new_row),
      .down       (down),
      .up         (up)
   );

   // Fit row data into the fixed result fields, dropping rows that do not fit
   assign led_ext  = {{bmsd_pkg::LED_W{1'b0}}, rd_row.colour};
   assign down_ext = {{bmsd_pkg::MASK_W{1'b0}}, down};
   assign up_ext   = {{bmsd_pkg::MASK_W{1'b0}}, up};
   assign col_ext  = {{bmsd_pkg::SCAN_COL_W{1'b0}}, s1_col_ff};

   // Load the output register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_col_ff  <= col_ext[bmsd_pkg::SCAN_COL_W-1:0];
         out_led_ff  <= led_ext[bmsd_pkg::LED_W-1:0];
         out_down_ff <= down_ext[bmsd_pkg::MASK_W-1:0];
         out_up_ff   <= up_ext[bmsd_pkg::MASK_W-1:0];
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.scan_column   = out_col_ff;
   assign rsp_if.led_drive     = out_led_ff;
   assign rsp_if.key_down_mask = out_down_ff;
   assign rsp_if.key_up_mask   = out_up_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad scan and debounce core. A short table
// of scan slots is walked first, then random key press/release sequences
// with bounce and noise run under several debounce limits. Each result is
// compared against its typed table row, else an in-bench counter/colour model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int KEYS           = bmsd_pkg::NUM_COLUMNS * bmsd_pkg::NUM_ROWS;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int HOLDOFF_AFTER  = 300;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int REPORT_MAX     = 10;
   localparam int NUM_DIRECTED   = 24;
   localparam int NUM_PHASES     = 8;

   typedef struct packed {
      logic [bmsd_pkg::SCAN_COL_W-1:0] scan_column;
      logic [bmsd_pkg::LED_W-1:0]      led_drive;
      logic [bmsd_pkg::MASK_W-1:0]     key_down_mask;
      logic [bmsd_pkg::MASK_W-1:0]     key_up_mask;
   } slot_result_type;

   typedef struct packed {
      logic [bmsd_pkg::LEVEL_W-1:0] levels;
      logic                         typed;
      slot_result_type              res;
   } directed_row_type;

   typedef struct packed {
      bmsd_pkg::reg_index_type         index;
      logic [bmsd_pkg::CSR_DATA_W-1:0] value;
      logic [15:0]                     items;
      logic                            quiet;
   } phase_type;

   // Directed slots, limit at its reset value of 3. Typed rows: an all
   // released sweep after reset, the third pressed sweep reaching the limit,
   // and the sweep held at the limit showing colour 1 on every key.
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{4'hF, 1'b1, '{2'd0, 8'h00, 4'h0, 4'h0}},
      '{4'hF, 1'b1, '{2'd1, 8'h00, 4'h0, 4'h0}},
      '{4'hF, 1'b1, '{2'd2, 8'h00, 4'h0, 4'h0}},
      '{4'hF, 1'b1, '{2'd3, 8'h00, 4'h0, 4'h0}},
      '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0},
      '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0}, '{4'h0, 1'b0, '0},
      '{4'h0, 1'b1, '{2'd0, 8'h00, 4'hF, 4'h0}},
      '{4'h0, 1'b1, '{2'd1, 8'h00, 4'hF, 4'h0}},
      '{4'h0, 1'b1, '{2'd2, 8'h00, 4'hF, 4'h0}},
      '{4'h0, 1'b1, '{2'd3, 8'h00, 4'hF, 4'h0}},
      '{4'h0, 1'b1, '{2'd0, 8'h55, 4'h0, 4'h0}},
      '{4'h0, 1'b1, '{2'd1, 8'h55, 4'h0, 4'h0}},
      '{4'h0, 1'b1, '{2'd2, 8'h55, 4'h0, 4'h0}},
      '{4'h0, 1'b1, '{2'd3, 8'h55, 4'h0, 4'h0}},
      '{4'hF, 1'b0, '0}, '{4'hA, 1'b0, '0}, '{4'h5, 1'b0, '0}, '{4'hF, 1'b0, '0}
   };

   // Limit settings: top, bottom, zero, upper bits ignored, top again,
   // lowered under live counters, write to the unused index, back to reset.
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd15,        16'd170, 1'b0},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd1,         16'd120, 1'b0},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd0,         16'd100, 1'b1},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'hFFFF_FFF7, 16'd150, 1'b0},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd15,        16'd150, 1'b0},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd2,         16'd120, 1'b0},
      '{bmsd_pkg::REG_UNUSED,         32'h0000_000C, 16'd100, 1'b0},
      '{bmsd_pkg::REG_DEBOUNCE_LIMIT, 32'd3,         16'd100, 1'b1}
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bmsd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bmsd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bmsd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   bmsd_req_if req_if ();
   bmsd_rsp_if rsp_if ();

   button_matrix_scan_debounce_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model state of the keypad
   logic [bmsd_pkg::CNT_W-1:0]       cfg_limit;
   logic [bmsd_pkg::COL_W-1:0]       next_column;
   logic [bmsd_pkg::CNT_W-1:0]       key_count  [KEYS];
   logic [bmsd_pkg::COLOUR_BITS-1:0] key_colour [KEYS];

   // Random key pattern held per column
   logic [bmsd_pkg::LEVEL_W-1:0] held_levels [bmsd_pkg::NUM_COLUMNS];
   int                           hold_left   [bmsd_pkg::NUM_COLUMNS];

   slot_result_type slot_expect_q[$];
   int  fail_count   = 0;
   int  results_seen = 0;
   int  items_sent   = 0;
   int  cycle_count  = 0;
   bit  no_idle      = 1'b0;

   always #(CLK_HALF) clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("button_matrix_scan_debounce_core verification failed");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%s", msg);
   endtask

   // Advance the keypad model by one scan slot and return its result
   function automatic slot_result_type predict_slot(
      input logic [bmsd_pkg::LEVEL_W-1:0] levels);
      slot_result_type            res;
      int                         r;
      int                         k;
      logic [bmsd_pkg::CNT_W-1:0] cnt;
      res = '0;
      res.scan_column = next_column;
      for (r = 0; r < bmsd_pkg::NUM_ROWS; r++) begin
         k = next_column * bmsd_pkg::NUM_ROWS + r;
         res.led_drive[r*bmsd_pkg::COLOUR_BITS +: bmsd_pkg::COLOUR_BITS] = key_colour[k];
         cnt = key_count[k];
         if (!levels[r]) begin
            if (cnt < cfg_limit) begin
               cnt = cnt + 1'b1;
               if (cnt == cfg_limit) begin
                  res.key_down_mask[r] = 1'b1;
                  key_colour[k] = key_colour[k] + 1'b1;
               end
            end
         end else if (cnt != '0) begin
            cnt = cnt - 1'b1;
            if (cnt == '0) res.key_up_mask[r] = 1'b1;
         end
         key_count[k] = cnt;
      end
      next_column = (next_column == bmsd_pkg::COL_W'(bmsd_pkg::NUM_COLUMNS - 1)) ?
                    '0 : next_column + 1'b1;
      return res;
   endfunction

   // Mostly short gaps, a few long ones; none in a quiet phase
   function automatic int pick_gap();
      int sel;
      if (no_idle) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Held pattern per column with bounce, plus some pure noise slots
   function automatic logic [bmsd_pkg::LEVEL_W-1:0] next_levels();
      logic [bmsd_pkg::LEVEL_W-1:0] lv;
      int                           r;
      if (hold_left[next_column] == 0) begin
         held_levels[next_column] = bmsd_pkg::LEVEL_W'($urandom_range(0, 15));
         hold_left[next_column]   = $urandom_range(1, int'(cfg_limit) + 5);
      end
      hold_left[next_column]--;
      if ($urandom_range(0, 99) < 15) return bmsd_pkg::LEVEL_W'($urandom_range(0, 15));
      lv = held_levels[next_column];
      for (r = 0; r < bmsd_pkg::LEVEL_W; r++) begin
         if ($urandom_range(0, 99) < 3) lv[r] = ~lv[r];
      end
      return lv;
   endfunction

   // Offer one item, hold it until accepted, then log its expected result
   task automatic push_slot(input logic [bmsd_pkg::LEVEL_W-1:0] levels,
                            input logic typed, input slot_result_type typed_res);
      slot_result_type predicted;
      req_if.valid      <= 1'b1;
      req_if.row_levels <= levels;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_slot(levels);
      slot_expect_q.push_back(typed ? typed_res : predicted);
      items_sent++;
   endtask

   // Drop valid for a random gap, or for good after the last item
   task automatic idle_after(input bit last);
      int gap;
      gap = pick_gap();
      if (last || gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (slot_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input bmsd_pkg::reg_index_type index,
                            input logic [bmsd_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bmsd_pkg::CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (index == bmsd_pkg::REG_DEBOUNCE_LIMIT) cfg_limit = value[bmsd_pkg::CNT_W-1:0];
      // Hold the bus idle before the task returns
      @(posedge clock);
   endtask

   // Read the limit back and check it against the model
   task automatic csr_check_limit();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= bmsd_pkg::CSR_ADDR_W'({bmsd_pkg::REG_DEBOUNCE_LIMIT, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== bmsd_pkg::CSR_DATA_W'(cfg_limit))
         note_failure($sformatf("limit readback: expected %0d, got %0h", cfg_limit,
                                csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input int slot,
                              input logic [bmsd_pkg::LED_W-1:0] want,
                              input logic [bmsd_pkg::LED_W-1:0] got);
      if (got !== want)
         note_failure($sformatf("result %0d %s: expected %0h, got %0h", slot, name, want, got));
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      slot_result_type seen;
      slot_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = '{rsp_if.scan_column, rsp_if.led_drive, rsp_if.key_down_mask,
                  rsp_if.key_up_mask};
         if (slot_expect_q.size() == 0) begin
            note_failure($sformatf("result %0d with nothing expected: %0h", results_seen, seen));
         end else begin
            want = slot_expect_q.pop_front();
            check_field("scan_column", results_seen, bmsd_pkg::LED_W'(want.scan_column),
                        bmsd_pkg::LED_W'(seen.scan_column));
            check_field("led_drive", results_seen, want.led_drive, seen.led_drive);
            check_field("key_down_mask", results_seen, bmsd_pkg::LED_W'(want.key_down_mask),
                        bmsd_pkg::LED_W'(seen.key_down_mask));
            check_field("key_up_mask", results_seen, bmsd_pkg::LED_W'(want.key_up_mask),
                        bmsd_pkg::LED_W'(seen.key_up_mask));
         end
         results_seen++;
      end
   end

   // Result side: random stalls, and one long hold-off to back up the core
   initial begin
      int stall_left;
      bit holdoff_done;
      stall_left   = 0;
      holdoff_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            stall_left   = HOLDOFF_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Main sequence
   initial begin
      int i;
      int p;
      cfg_limit   = bmsd_pkg::LIMIT_RESET;
      next_column = '0;
      for (i = 0; i < KEYS; i++) begin
         key_count[i]  = '0;
         key_colour[i] = '0;
      end
      for (i = 0; i < bmsd_pkg::NUM_COLUMNS; i++) begin
         held_levels[i] = '1;
         hold_left[i]   = 0;
      end
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.row_levels <= '1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_limit();

      // Walk the directed table
      for (i = 0; i < NUM_DIRECTED; i++) begin
         push_slot(DIRECTED_ROWS[i].levels, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
         idle_after(i == NUM_DIRECTED - 1);
      end
      wait_drained();

      // Random phases, each after its own register write
      for (p = 0; p < NUM_PHASES; p++) begin
         no_idle = PHASES[p].quiet;
         csr_write(PHASES[p].index, PHASES[p].value);
         csr_check_limit();
         for (i = 0; i < int'(PHASES[p].items); i++) begin
            push_slot(next_levels(), 1'b0, '0);
            idle_after(i == int'(PHASES[p].items) - 1);
         end
         wait_drained();
      end

      if (slot_expect_q.size() != 0)
         note_failure($sformatf("%0d results never arrived", slot_expect_q.size()));
      $display("Covered %0d scan slots and %0d results over %0d limit settings (0 to 15),",
               items_sent, results_seen, NUM_PHASES + 1);
      $display("with bounce, noise, an ignored register write and a %0d-cycle output hold-off.",
               HOLDOFF_CYCLES);
      if (fail_count == 0) begin
         $display("button_matrix_scan_debounce_core verification clean");
      end else begin
         $display("button_matrix_scan_debounce_core verification failed");
      end
      $finish;
   end

endmodule
